// File: sv/rfpar_pkg.sv
package rfpar_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_INIT_AMP   = 3'd0,
    CFG_PHASE_STEP = 3'd1,
    CFG_BIAS       = 3'd2,
    CFG_WINDOW     = 3'd3,
    CFG_GAIN       = 3'd4,
    CFG_DAMPING    = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 3;

  // Register reset values
  localparam logic [31:0] InitAmpRst = 32'd6553600;
  localparam logic [23:0] WindowRst  = 24'd1000;
  localparam logic [15:0] DampingRst = 16'd6554;

  // Fixed-point constants
  localparam logic [63:0] Q30One      = 64'd1073741824;
  localparam logic [63:0] TwoPiQ30    = 64'd6746518852;
  localparam logic [31:0] FactorLimit = 32'd429496730;
  localparam logic [57:0] Q16One      = 58'd65536;

  // Request to the shared multiplier
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // Truncated Taylor series for cos, Q2.30 in and out
  function automatic logic [63:0] poly_cos(logic [63:0] x2);
    logic [63:0] t;
    t = Q30One - x2 / 64'd56;
    t = Q30One - ((x2 * t) >> 30) / 64'd30;
    t = Q30One - ((x2 * t) >> 30) / 64'd12;
    t = Q30One - ((x2 * t) >> 30) / 64'd2;
    return t;
  endfunction

  // Truncated Taylor series for sin, Q2.30 in and out
  function automatic logic [63:0] poly_sin(logic [63:0] th, logic [63:0] x2);
    logic [63:0] t;
    t = Q30One - x2 / 64'd72;
    t = Q30One - ((x2 * t) >> 30) / 64'd42;
    t = Q30One - ((x2 * t) >> 30) / 64'd20;
    t = Q30One - ((x2 * t) >> 30) / 64'd6;
    return (th * t) >> 30;
  endfunction

  // Table entry k of 2^aw: cos(2*pi*k/2^aw) in Q2.30, folded to one octant
  function automatic logic signed [31:0] cos_entry(int unsigned k, int unsigned aw);
    logic [63:0] u;
    logic [1:0]  q;
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] pc;
    logic [63:0] ps;
    logic [31:0] c;
    logic [31:0] s;
    logic [31:0] r;
    u  = 64'(k) << (32 - aw);
    q  = u[31:30];
    f  = {34'd0, u[29:0]};
    g  = (f < 64'h2000_0000) ? f : (64'h4000_0000 - f);
    th = (g * TwoPiQ30) >> 32;
    x2 = (th * th) >> 30;
    pc = poly_cos(x2);
    ps = poly_sin(th, x2);
    c  = (f < 64'h2000_0000) ? pc[31:0] : ps[31:0];
    s  = (f < 64'h2000_0000) ? ps[31:0] : pc[31:0];
    case (q)
      2'd0:    r = c;
      2'd1:    r = -s;
      2'd2:    r = -c;
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

// File: sv/rfpar_mul.sv
module rfpar_mul
  import rfpar_pkg::*;
(
  input  logic        clk_i,
  input  mul_req_t    req_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // Shared 32x32 multiplier, product registered, held while idle
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= 64'(req_i.a) * 64'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

// File: sv/rfpar_cos_rom.sv
module rfpar_cos_rom
  import rfpar_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic signed [31:0]       data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic signed [31:0] tbl   [DEPTH];
  logic signed [31:0] data_q;

  // Constant cosine table, Q2.30, built at elaboration
  for (genvar k = 0; k < DEPTH; k++) begin : g_tbl
    assign tbl[k] = cos_entry(k, AW);
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    data_q <= tbl[addr_i];
  end

  assign data_o = data_q;

endmodule

// File: sv/rf_power_amplitude_regulator_top.sv
// RF drive with power regulation. Each input word is one control step carrying
// a measured power sample (signed Q16.16); each step returns one output word with
// the drive voltage amplitude*cos(phase)+bias (signed Q16.16, saturated), the
// current amplitude and a flag set when the step closed a power window and
// corrected the amplitude by a factor held within [0.9, 1.1]. A step that does
// not close a window goes from acceptance back to ready through the table lookup
// wait, one product and output; a closing step takes longer, as its five products
// (average, deviation times damping, amplitude change, voltage) all go through
// the one 32x32 multiplier in turn. The result sits in an output register, so
// the next step is accepted while it waits. COS_TABLE_DEPTH must be a power of
// two; the table is constant and needs no load after reset. Configuration
// writes are taken at any time but must only be made while no step is in work.
module rf_power_amplitude_regulator_top
  import rfpar_pkg::*;
#(
  parameter int unsigned COS_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS      = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] power_sample_i,
  // output words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] voltage_o,
  output logic [31:0]        amplitude_o,
  output logic               updated_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned SW = (PHASE_BITS > 32) ? PHASE_BITS : 32;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_LOOK = 10'b00_0000_0010,
    S_MLO  = 10'b00_0000_0100,
    S_MHI  = 10'b00_0000_1000,
    S_DEV  = 10'b00_0001_0000,
    S_MDMP = 10'b00_0010_0000,
    S_MAMP = 10'b00_0100_0000,
    S_UPD  = 10'b00_1000_0000,
    S_MV   = 10'b01_0000_0000,
    S_VOUT = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [31:0]        init_amp_q;
  logic [31:0]        phase_step_q;
  logic signed [31:0] bias_q;
  logic [23:0]        window_q;
  logic [31:0]        gain_q;
  logic [15:0]        damping_q;

  // step state
  logic                  started_q;
  logic signed [55:0]    sum_q;
  logic [23:0]           count_q;
  logic [31:0]           amp_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic                  close_q;

  // working registers
  logic [31:0] acc_q;
  logic [31:0] dev_q;
  logic        dev_neg_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] voltage_q;
  logic [31:0]        amplitude_q;
  logic               updated_q;

  logic               accept;
  logic               out_load;
  mul_req_t           mul_req;
  logic [63:0]        prod;
  logic signed [31:0] cos_val;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_VOUT) && (!out_valid_q || out_ready_i);

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_amp_q   <= InitAmpRst;
      phase_step_q <= '0;
      bias_q       <= '0;
      window_q     <= WindowRst;
      gain_q       <= '0;
      damping_q    <= DampingRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INIT_AMP:   init_amp_q   <= cfg_data_i;
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
        CFG_BIAS:       bias_q       <= cfg_data_i;
        CFG_WINDOW:     window_q     <= cfg_data_i[23:0];
        CFG_GAIN:       gain_q       <= cfg_data_i;
        CFG_DAMPING:    damping_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // window sum with saturation at the signed 56-bit limits
  logic [56:0] sum_wide;
  logic [55:0] sum_sat;
  always_comb begin
    sum_wide = {sum_q[55], sum_q} + {{25{power_sample_i[31]}}, power_sample_i};
    if (sum_wide[56] != sum_wide[55]) begin
      sum_sat = sum_wide[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
    end else begin
      sum_sat = sum_wide[55:0];
    end
  end

  // window count, zero window acts as one
  logic [23:0] count_inc;
  logic [23:0] wsteps;
  assign count_inc = count_q + 24'd1;
  assign wsteps    = (window_q == 24'd0) ? 24'd1 : window_q;

  // phase step
  logic [SW-1:0] step_w;
  assign step_w = SW'(phase_step_q);

  // magnitude of the window sum, split for two products
  logic [55:0] sum_mag;
  assign sum_mag = sum_q[55] ? (~sum_q + 56'd1) : sum_q;

  // deviation of the normalized average from one, magnitude clamped to 32 bits
  logic [56:0] avg;
  logic [57:0] dev_mag;
  logic        dev_neg;
  logic [31:0] dev_clamp;
  always_comb begin
    avg = {1'b0, prod[55:0]} + 57'(acc_q);
    if (sum_q[55]) begin
      dev_mag = {1'b0, avg} + Q16One;
      dev_neg = 1'b1;
    end else if ({1'b0, avg} >= Q16One) begin
      dev_mag = {1'b0, avg} - Q16One;
      dev_neg = 1'b0;
    end else begin
      dev_mag = Q16One - {1'b0, avg};
      dev_neg = 1'b1;
    end
    dev_clamp = (|dev_mag[57:32]) ? 32'hFFFF_FFFF : dev_mag[31:0];
  end

  // limited correction and new amplitude
  logic [31:0] fact_mag;
  logic [63:0] delta_rnd;
  logic [32:0] amp_sum;
  logic [31:0] amp_new;
  always_comb begin
    fact_mag  = (prod > 64'(FactorLimit)) ? FactorLimit : prod[31:0];
    delta_rnd = prod + 64'h8000_0000;
    amp_sum   = {1'b0, amp_q} + {1'b0, delta_rnd[63:32]};
    if (dev_neg_q) begin
      amp_new = amp_sum[32] ? 32'hFFFF_FFFF : amp_sum[31:0];
    end else begin
      amp_new = amp_q - delta_rnd[63:32];
    end
  end

  // voltage: round Q.46 product to Q.16, add bias, saturate
  logic [31:0]        cos_mag;
  logic [63:0]        volt_rnd;
  logic signed [34:0] volt_mag;
  logic signed [34:0] volt_sum;
  logic signed [31:0] volt_sat;
  always_comb begin
    cos_mag  = cos_val[31] ? (~cos_val + 32'd1) : cos_val;
    volt_rnd = prod + 64'h2000_0000;
    volt_mag = {1'b0, volt_rnd[63:30]};
    volt_sum = (cos_val[31] ? -volt_mag : volt_mag) + {{3{bias_q[31]}}, bias_q};
    if (volt_sum[34:31] != {4{volt_sum[31]}}) begin
      volt_sat = volt_sum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      volt_sat = volt_sum[31:0];
    end
  end

  // multiplier operand select
  always_comb begin
    mul_req = '0;
    case (state_q)
      S_MLO: begin
        mul_req.en = 1'b1;
        mul_req.a  = sum_mag[31:0];
        mul_req.b  = gain_q;
      end
      S_MHI: begin
        mul_req.en = 1'b1;
        mul_req.a  = {8'd0, sum_mag[55:32]};
        mul_req.b  = gain_q;
      end
      S_MDMP: begin
        mul_req.en = 1'b1;
        mul_req.a  = {16'd0, damping_q};
        mul_req.b  = dev_q;
      end
      S_MAMP: begin
        mul_req.en = 1'b1;
        mul_req.a  = amp_q;
        mul_req.b  = fact_mag;
      end
      S_MV: begin
        mul_req.en = 1'b1;
        mul_req.a  = amp_q;
        mul_req.b  = cos_mag;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_LOOK;
      S_LOOK: state_d = close_q ? S_MLO : S_MV;
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_DEV;
      S_DEV:  state_d = S_MDMP;
      S_MDMP: state_d = S_MAMP;
      S_MAMP: state_d = S_UPD;
      S_UPD:  state_d = S_MV;
      S_MV:   state_d = S_VOUT;
      S_VOUT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state and step state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
      amp_q       <= InitAmpRst;
      phase_q     <= '0;
      close_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        sum_q   <= sum_sat;
        count_q <= count_inc;
        close_q <= (count_inc >= wsteps);
        phase_q <= phase_q + step_w[PHASE_BITS-1:0];
        if (!started_q) begin
          amp_q     <= init_amp_q;
          started_q <= 1'b1;
        end
      end
      if (state_q == S_UPD) begin
        sum_q   <= '0;
        count_q <= '0;
        amp_q   <= amp_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_MHI) begin
      acc_q <= prod[63:32];
    end
    if (state_q == S_DEV) begin
      dev_q     <= dev_clamp;
      dev_neg_q <= dev_neg;
    end
    if (out_load) begin
      voltage_q   <= volt_sat;
      amplitude_q <= amp_q;
      updated_q   <= close_q;
    end
  end

  rfpar_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  rfpar_cos_rom #(
    .DEPTH (COS_TABLE_DEPTH)
  ) u_cos_rom (
    .clk_i  (clk_i),
    .addr_i (phase_q[PHASE_BITS-1 -: AW]),
    .data_o (cos_val)
  );

  assign out_valid_o = out_valid_q;
  assign voltage_o   = voltage_q;
  assign amplitude_o = amplitude_q;
  assign updated_o   = updated_q;

  // a closing step clears the window
  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (sum_q == '0 && count_q == '0))
    else $error("window not cleared after update");

  // an upward correction never lowers the amplitude
  a_amp_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && dev_neg_q) |=> (amp_q >= $past(amp_q)))
    else $error("amplitude fell on upward correction");

  // busy in the lookup state after a word is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready right after accept");

  // the output register is loaded only when free or being drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(voltage_q)))
    else $error("pending output word overwritten");

endmodule

// File: tb/sv/tb_rf_power_amplitude_regulator_top.sv
module tb_rf_power_amplitude_regulator_top;
  import rfpar_pkg::*;

  localparam int unsigned RandomItems = 1100;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;

  // Fixed-point constants of the regulator
  localparam logic [63:0] UnitQ30   = 64'h4000_0000;
  localparam logic [63:0] TurnQ30   = 64'd6746518852;
  localparam longint      DevCap    = 64'sd1099511627776;
  localparam longint      FactorCap = 64'sd429496730;
  localparam longint      SumHigh   = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint      SumLow    = 64'shFF80_0000_0000_0000;
  localparam longint      VoltHigh  = 64'sd2147483647;
  localparam longint      VoltLow   = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] voltage;
    logic [31:0]        amplitude;
    logic               updated;
  } drive_word_t;

  // One line of the directed sequence: a register write or a power sample
  typedef struct {
    bit          is_write;
    cfg_idx_e    reg_idx;
    logic [31:0] data;
    bit          known;
    drive_word_t want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic signed [31:0]  power_sample = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]         cfg_data = '0;
  logic                in_ready;
  logic                out_valid;
  logic                cfg_ready;
  logic signed [31:0]  voltage;
  logic [31:0]         amplitude;
  logic                updated;

  // Register copies
  logic [31:0]        init_amp_r   = InitAmpRst;
  logic [31:0]        phase_step_r = '0;
  logic signed [31:0] bias_r       = '0;
  logic [23:0]        window_r     = WindowRst;
  logic [31:0]        gain_r       = '0;
  logic [15:0]        damping_r    = DampingRst;

  // Regulator state
  longint      sum_q     = 0;
  logic [23:0] count_q   = '0;
  logic [31:0] amp_q     = InitAmpRst;
  logic [31:0] phase_q   = '0;
  bit          started_q = 1'b0;

  drive_word_t drive_words_due[$];
  plan_row_t   plan[$];
  int          errors = 0;
  bit          burst  = 1'b0;

  rf_power_amplitude_regulator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .power_sample_i (power_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .voltage_o      (voltage),
    .amplitude_o    (amplitude),
    .updated_o      (updated),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Nested Taylor product in Q2.30: 1 - x/d3*(1 - x/d2*(1 - x/d1*(1 - x/d0)))
  function automatic logic [63:0] taylor_q30(logic [63:0] sq, int unsigned d0,
                                             int unsigned d1, int unsigned d2,
                                             int unsigned d3);
    logic [63:0] t;
    t = UnitQ30;
    t = UnitQ30 - ((sq * t) >> 30) / d0;
    t = UnitQ30 - ((sq * t) >> 30) / d1;
    t = UnitQ30 - ((sq * t) >> 30) / d2;
    t = UnitQ30 - ((sq * t) >> 30) / d3;
    return t;
  endfunction

  // Cosine of table slot k (of 1024) in Q2.30, evaluated within one octant
  function automatic longint cos_q30(logic [9:0] k);
    logic [63:0] frac;
    logic [63:0] ang;
    logic [63:0] sq;
    logic [63:0] tc;
    logic [63:0] ts;
    logic [63:0] near;
    logic [63:0] far;
    bit          lower;
    frac  = {32'd0, 2'b00, k[7:0], 22'd0};
    lower = (frac < 64'h2000_0000);
    ang   = ((lower ? frac : (64'h4000_0000 - frac)) * TurnQ30) >> 32;
    sq    = (ang * ang) >> 30;
    tc    = taylor_q30(sq, 56, 30, 12, 2);
    ts    = (ang * taylor_q30(sq, 72, 42, 20, 6)) >> 30;
    near  = lower ? tc : ts;
    far   = lower ? ts : tc;
    case (k[9:8])
      2'd0:    return longint'(near);
      2'd1:    return -longint'(far);
      2'd2:    return -longint'(near);
      default: return longint'(far);
    endcase
  endfunction

  // Window close: scale the amplitude by the limited correction factor
  function automatic void regulate_amplitude();
    logic [63:0] mag;
    logic [63:0] avg;
    logic [63:0] fa;
    logic [63:0] delta;
    logic [63:0] grown;
    longint      dev;
    longint      fm;
    mag = (sum_q < 0) ? 64'(-sum_q) : 64'(sum_q);
    avg = (mag >> 32) * {32'd0, gain_r}
        + (({32'd0, mag[31:0]} * {32'd0, gain_r}) >> 32);
    dev = (sum_q < 0) ? -longint'(avg) : longint'(avg);
    dev = dev - 64'sd65536;
    if (dev > DevCap) dev = DevCap;
    if (dev < -DevCap) dev = -DevCap;
    fm = -(longint'({48'd0, damping_r}) * dev);
    if (fm > FactorCap) fm = FactorCap;
    if (fm < -FactorCap) fm = -FactorCap;
    fa    = (fm < 0) ? 64'(-fm) : 64'(fm);
    delta = ({32'd0, amp_q} * fa + 64'h8000_0000) >> 32;
    grown = (fm < 0) ? ({32'd0, amp_q} - delta) : ({32'd0, amp_q} + delta);
    amp_q = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
  endfunction

  // One control step: window bookkeeping, phase advance, drive voltage
  function automatic drive_word_t step_drive(logic signed [31:0] s);
    drive_word_t w;
    logic [23:0] span;
    logic [63:0] cm;
    logic [63:0] pm;
    longint      c;
    longint      volt;
    span = (window_r == '0) ? 24'd1 : window_r;
    if (!started_q) begin
      amp_q     = init_amp_r;
      started_q = 1'b1;
    end
    sum_q = sum_q + longint'(s);
    if (sum_q > SumHigh) sum_q = SumHigh;
    if (sum_q < SumLow) sum_q = SumLow;
    count_q   = count_q + 24'd1;
    w.updated = 1'b0;
    if (count_q >= span) begin
      regulate_amplitude();
      sum_q     = 0;
      count_q   = '0;
      w.updated = 1'b1;
    end
    phase_q = phase_q + phase_step_r;
    c       = cos_q30(phase_q[31:22]);
    cm      = (c < 0) ? 64'(-c) : 64'(c);
    pm      = ({32'd0, amp_q} * cm + 64'h2000_0000) >> 30;
    volt    = (c < 0) ? -longint'(pm) : longint'(pm);
    volt    = volt + longint'(bias_r);
    if (volt > VoltHigh) volt = VoltHigh;
    if (volt < VoltLow) volt = VoltLow;
    w.voltage   = volt[31:0];
    w.amplitude = amp_q;
    return w;
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic void plan_write(cfg_idx_e idx, logic [31:0] data);
    plan_row_t r;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.data     = data;
    r.known    = 1'b0;
    r.want     = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_sample(logic [31:0] s, bit known, drive_word_t want);
    plan_row_t r;
    r.is_write = 1'b0;
    r.reg_idx  = CFG_INIT_AMP;
    r.data     = s;
    r.known    = known;
    r.want     = want;
    plan.push_back(r);
  endfunction

  // Random register value, leaning on the extremes
  function automatic logic [31:0] pick_reg_value(cfg_idx_e idx);
    logic [31:0] r;
    r = $urandom;
    case (idx)
      CFG_WINDOW: begin
        case ($urandom_range(0, 7))
          0:       r = '0;
          1:       r = 32'h00FF_FFFF;
          default: r = $urandom_range(1, 40);
        endcase
      end
      CFG_GAIN: begin
        case ($urandom_range(0, 7))
          0, 1:    r = '0;
          2:       r = 32'hFFFF_FFFF;
          3:       r = $urandom;
          default: r = (32'hFFFF_FFFF / $urandom_range(1, 40)) ^ ($urandom & 32'h0000_FFFF);
        endcase
      end
      CFG_DAMPING: begin
        case ($urandom_range(0, 3))
          0:       r = '0;
          1:       r = 32'h0000_FFFF;
          default: r = $urandom_range(0, 65535);
        endcase
      end
      CFG_BIAS: begin
        case ($urandom_range(0, 4))
          0:       r = 32'h8000_0000;
          1:       r = 32'h7FFF_FFFF;
          2:       r = 32'($urandom_range(0, 1 << 20)) - 32'd524288;
          default: r = $urandom;
        endcase
      end
      CFG_PHASE_STEP: begin
        case ($urandom_range(0, 4))
          0: r = '0;
          1: r = 32'hFFFF_FFFF;
          2: r = $urandom_range(0, 1 << 26);
          default: r = $urandom;
        endcase
      end
      default: r = $urandom;
    endcase
    return r;
  endfunction

  // Power sample: mostly near 1 W, some extremes and full-range noise
  function automatic logic [31:0] pick_sample();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       r = 32'h7FFF_FFFF;
          1:       r = 32'h8000_0000;
          2:       r = '0;
          default: r = 32'hFFFF_FFFF;
        endcase
      end
      1, 2:    r = $urandom;
      default: r = $urandom_range(0, 131072);
    endcase
    return r;
  endfunction

  // Present one sample word and predict its drive word at acceptance
  task automatic push_sample(input logic [31:0] s, input bit known,
                             input drive_word_t want);
    int          gap;
    drive_word_t w;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    power_sample <= s;
    do @(posedge clk_i); while (!in_ready);
    w = step_drive(s);
    drive_words_due.push_back(known ? want : w);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_INIT_AMP:   init_amp_r   = data;
      CFG_PHASE_STEP: phase_step_r = data;
      CFG_BIAS:       bias_r       = data;
      CFG_WINDOW:     window_r     = data[23:0];
      CFG_GAIN:       gain_r       = data;
      CFG_DAMPING:    damping_r    = data[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off samples until every due drive word has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (drive_words_due.size() != 0);
  endtask

  // Stimulus
  initial begin
    int       sent;
    int       n;
    cfg_idx_e idx;
    sent = 0;

    // Saturating drive: max amplitude, phase at 0 and half turn, bias extremes
    plan_write(CFG_INIT_AMP, 32'h0000_0000);
    plan_write(CFG_INIT_AMP, 32'hFFFF_FFFF);
    plan_write(CFG_WINDOW, 32'd1);
    plan_write(CFG_DAMPING, 32'h0000_FFFF);
    plan_sample(32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    plan_sample(32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    plan_write(CFG_BIAS, 32'h8000_0000);
    plan_sample(32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    plan_write(CFG_PHASE_STEP, 32'h8000_0000);
    plan_sample(32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1});
    plan_sample(32'h0000_0001, 1'b1, '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    plan_write(CFG_BIAS, 32'h7FFF_FFFF);
    plan_sample(32'h0001_0000, 1'b1, '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1});
    // Full gain: large averages pull the amplitude down by the lower limit
    plan_write(CFG_GAIN, 32'hFFFF_FFFF);
    plan_sample(32'h7FFF_FFFF, 1'b0, '0);
    plan_sample(32'h8000_0000, 1'b0, '0);
    plan_sample(32'h0001_0000, 1'b0, '0);
    plan_write(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    plan_sample(32'h0000_0000, 1'b0, '0);
    plan_sample(32'h1234_5678, 1'b0, '0);
    // Walk the cosine table in coarse steps
    plan_write(CFG_PHASE_STEP, 32'h0400_0000);
    plan_write(CFG_BIAS, 32'h0000_0000);
    plan_sample(32'h0000_8000, 1'b0, '0);
    plan_sample(32'hFFFF_0000, 1'b0, '0);
    plan_sample(32'h0002_0000, 1'b0, '0);
    plan_sample(32'h0001_0000, 1'b0, '0);
    // Zero window behaves as one step
    plan_write(CFG_WINDOW, 32'd0);
    plan_sample(32'h0000_8000, 1'b0, '0);
    // No damping leaves the amplitude alone
    plan_write(CFG_DAMPING, 32'd0);
    plan_sample(32'h7FFF_FFFF, 1'b0, '0);
    // Long window, then shortened below the running count
    plan_write(CFG_DAMPING, 32'd6554);
    plan_write(CFG_WINDOW, 32'h00FF_FFFF);
    plan_write(CFG_GAIN, 32'h0001_0000);
    plan_sample(32'h0001_0000, 1'b0, '0);
    plan_sample(32'h0003_0000, 1'b0, '0);
    plan_sample(32'h7FFF_FFFF, 1'b0, '0);
    plan_sample(32'h0000_4000, 1'b0, '0);
    plan_write(CFG_WINDOW, 32'd2);
    plan_sample(32'h0001_0000, 1'b0, '0);
    plan_sample(32'h0001_0000, 1'b0, '0);

    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].data);
      end else begin
        push_sample(plan[i].data, plan[i].known, plan[i].want);
      end
    end

    // Random phases: a few register writes, then a run of samples
    while (sent < RandomItems) begin
      wait_idle();
      repeat ($urandom_range(1, 3)) begin
        idx = cfg_idx_e'($urandom_range(0, 5));
        write_reg(idx, pick_reg_value(idx));
      end
      burst = ($urandom_range(0, 3) == 0);
      n     = $urandom_range(20, 60);
      repeat (n) begin
        push_sample(pick_sample(), 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && drive_words_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Drive word sink with random stalls; compare against the oldest due word
  initial begin
    int          gap;
    drive_word_t due;
    wait (rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      if (drive_words_due.size() == 0) begin
        $display("%0t: unexpected drive word: voltage %h amplitude %h updated %b",
                 $time, voltage, amplitude, updated);
        errors++;
      end else begin
        due = drive_words_due.pop_front();
        if (voltage !== due.voltage) begin
          $display("%0t: voltage expected %h, got %h", $time, due.voltage, voltage);
          errors++;
        end
        if (amplitude !== due.amplitude) begin
          $display("%0t: amplitude expected %h, got %h", $time, due.amplitude,
                   amplitude);
          errors++;
        end
        if (updated !== due.updated) begin
          $display("%0t: updated expected %b, got %b", $time, due.updated, updated);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
sv/rfpar_pkg.sv
sv/rfpar_mul.sv
sv/rfpar_cos_rom.sv
sv/rf_power_amplitude_regulator_top.sv
tb/sv/tb_rf_power_amplitude_regulator_top.sv
